// ===== sv/dot_pkg.sv =====
// Shared types, sizes and codes for the depth ordering table.
package dot_pkg;

    localparam int SLOTS   = 1024;
    localparam int ENTRIES = 1024;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CURSOR_W = $clog2(SLOTS + 1);
    localparam int COUNT_W  = $clog2(ENTRIES + 1);
    localparam int ROW_W    = 16;
    localparam int ROWS_W   = 12;
    localparam int FIELD_W  = 10;
    // A positive row has at most ROW_W-1 magnitude bits, scaled by SLOTS-1.
    localparam int DIVIDEND_W = ROW_W - 1 + SLOT_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_FETCH  = 2'd2,
        MODE_NONE   = 2'd3
    } dot_mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOSLOT = 2'd2,
        ST_END    = 2'd3
    } dot_status_t;

    typedef struct packed {
        dot_mode_t                 mode;
        logic signed [ROW_W-1:0]   row;
    } dot_in_t;

    typedef struct packed {
        dot_status_t               status;
        logic [FIELD_W-1:0]        entry_number;
        logic [FIELD_W-1:0]        slot;
    } dot_out_t;

endpackage

// ===== sv/dot_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the row to slot mapping.
module dot_div
    import dot_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [ROWS_W-1:0]     divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [ROWS_W-1:0]     rem_reg, rem_next;
    logic [ROWS_W-1:0]     dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [ROWS_W:0]       trial;
    logic [ROWS_W:0]       diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = DIV_CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            // Trial subtract; the remainder always stays below the divisor.
            if (!diff[ROWS_W])
            begin
                rem_next = diff[ROWS_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ROWS_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/depth_ordering_table_insert.sv =====
// Top level of the depth ordering table: command sequencer and slot memory.
//
// Primitives are sorted by screen row into a table of SLOTS slots and read
// back in ascending slot order. A command beat is taken when start is high
// and busy is low; each command gives exactly one result beat, shown on
// result for one cycle with done high. The receiver cannot stall, so it must
// take every beat in the cycle it appears. After reset the block sweeps the
// slot memory with busy high before the first command is taken; screen_rows
// may be written at any time busy is low. The work per command is set by
// the single-port slot memory with its registered read and by the bit-serial
// divider: a clear sweeps the memory again; an insert reads and checks each
// probed slot in turn, after a division of the row when it is positive; a
// fetch reads and checks each slot in turn from the read cursor on; a
// full-store reject, a fetch with the cursor at the end and an unused mode
// answer straight from idle. The memory holds a used flag and an entry
// number per slot.
module depth_ordering_table_insert
    import dot_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dot_in_t           cmd,
    input  logic              cfg_wr_en,
    input  logic [ROWS_W-1:0] cfg_wr_data,
    output logic              done,
    output dot_out_t          result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_SCAN_RD,
        S_SCAN_CHK
    } state_t;

    localparam int MEM_W = FIELD_W + 1;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     home_reg, home_next;
    logic                  clr_emit_reg, clr_emit_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [CURSOR_W-1:0]   cursor_reg, cursor_next;
    logic [ROWS_W-1:0]     rows_reg, rows_next;
    logic                  done_reg, done_next;
    dot_out_t              result_reg, result_next;

    // Slot memory: bit FIELD_W is the used flag, the rest the entry number.
    logic [MEM_W-1:0]      mem [SLOTS];
    logic [MEM_W-1:0]      rd_reg;
    logic                  mem_we;
    logic [MEM_W-1:0]      mem_wdata;

    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVIDEND_W-1:0] scaled_row;
    logic [ROWS_W-1:0]     divisor;
    logic                  row_positive;
    logic                  rd_used;

    assign row_positive = !cmd.row[ROW_W-1] && (cmd.row != '0);
    // The multiply by SLOTS-1 is by a constant and stays narrow.
    assign scaled_row   = DIVIDEND_W'(cmd.row[ROW_W-2:0]) * DIVIDEND_W'(SLOTS - 1);
    // A zero screen height behaves as one row.
    assign divisor      = (rows_reg == '0) ? ROWS_W'(1) : rows_reg;
    assign rd_used      = rd_reg[FIELD_W];

    dot_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled_row),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        home_next     = home_reg;
        clr_emit_next = clr_emit_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        rows_next     = cfg_wr_en ? cfg_wr_data : rows_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        div_start     = 1'b0;
        mem_we        = 1'b0;
        mem_wdata     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.mode)
                        MODE_CLEAR:
                        begin
                            count_next    = '0;
                            cursor_next   = '0;
                            idx_next      = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg >= COUNT_W'(ENTRIES))
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: ST_FULL, entry_number: '0, slot: '0};
                            end
                            else if (row_positive)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                            else
                            begin
                                home_next  = '0;
                                idx_next   = '0;
                                state_next = S_PROBE_RD;
                            end
                        end
                        MODE_FETCH:
                        begin
                            if (cursor_reg >= CURSOR_W'(SLOTS))
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: ST_END, entry_number: '0, slot: '0};
                            end
                            else
                            begin
                                idx_next   = cursor_reg[SLOT_W-1:0];
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: ST_END, entry_number: '0, slot: '0};
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next    = S_IDLE;
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: ST_OK, entry_number: '0, slot: '0};
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo > DIVIDEND_W'(SLOTS - 2))
                        home_next = SLOT_W'(SLOTS - 2);
                    else
                        home_next = div_quo[SLOT_W-1:0];
                    idx_next   = home_next;
                    state_next = S_PROBE_RD;
                end
            end

            S_PROBE_RD:
            begin
                state_next = S_PROBE_CHK;
            end

            S_PROBE_CHK:
            begin
                if (!rd_used)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = {1'b1, count_reg[FIELD_W-1:0]};
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK,
                                    entry_number: count_reg[FIELD_W-1:0],
                                    slot: FIELD_W'(idx_reg)};
                    count_next  = count_reg + 1'b1;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_NOSLOT, entry_number: '0, slot: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // The search runs upward while at or above home; once the top
                    // slot is hit it restarts just below home and runs downward.
                    if (idx_reg == SLOT_W'(SLOTS - 1))
                        idx_next = home_reg - 1'b1;
                    else if (idx_reg >= home_reg)
                        idx_next = idx_reg + 1'b1;
                    else
                        idx_next = idx_reg - 1'b1;
                    state_next = S_PROBE_RD;
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (rd_used)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_OK,
                                    entry_number: rd_reg[FIELD_W-1:0],
                                    slot: FIELD_W'(idx_reg)};
                    cursor_next = CURSOR_W'(idx_reg) + 1'b1;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    done_next   = 1'b1;
                    result_next = '{status: ST_END, entry_number: '0, slot: '0};
                    cursor_next = CURSOR_W'(SLOTS);
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs. Reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            home_reg     <= '0;
            clr_emit_reg <= 1'b0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            rows_reg     <= ROWS_W'(240);
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            home_reg     <= home_next;
            clr_emit_reg <= clr_emit_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            rows_reg     <= rows_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    // Single-port slot memory with a registered read at the current index.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= mem_wdata;
        rd_reg <= mem[idx_reg];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== test/dot_answer_checker.sv =====
// Checker for the depth ordering table: predicts every answer beat and compares it.
module dot_answer_checker
    import dot_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  dot_in_t           cmd,
    input  logic              cfg_wr_en,
    input  logic [ROWS_W-1:0] cfg_wr_data,
    input  logic              done,
    input  dot_out_t          result,
    output int                errors,
    output int                outstanding,
    output int                ok_hits,
    output int                full_hits,
    output int                noslot_hits,
    output int                end_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS_AT_RESET = 240;
    localparam int PRINT_LIMIT   = 40;

    logic [ROWS_W-1:0]  rows_cfg;
    bit                 slot_taken [SLOTS];
    logic [FIELD_W-1:0] slot_owner [SLOTS];
    int                 entries_used;
    int                 fetch_pos;
    dot_out_t           awaited_answers [$];
    int                 mismatch_count = 0;
    int                 hits [4];

    // Home slot of a row, scaled by the screen height and clamped below the top slot.
    function automatic int home_of(logic signed [ROW_W-1:0] row);
        int     height;
        longint scaled;
        height = (rows_cfg == 0) ? 1 : int'(rows_cfg);
        if (row <= 0)
            return 0;
        scaled = (longint'(SLOTS - 1) * longint'(row)) / longint'(height);
        if (scaled > SLOTS - 2)
            scaled = SLOTS - 2;
        return int'(scaled);
    endfunction

    // Applies one command beat to the table copy and returns the answer it must give.
    function automatic dot_out_t answer_for(dot_in_t c);
        dot_out_t a;
        int       home;
        int       idx;
        bit       upward;
        a = '0;
        case (c.mode)
            MODE_CLEAR:
            begin
                foreach (slot_taken[i])
                    slot_taken[i] = 1'b0;
                entries_used = 0;
                fetch_pos    = 0;
            end
            MODE_INSERT:
            begin
                if (entries_used >= ENTRIES)
                begin
                    a.status = ST_FULL;
                    return a;
                end
                home   = home_of(c.row);
                idx    = home;
                upward = 1'b1;
                while (slot_taken[idx])
                begin
                    if (idx == 0)
                    begin
                        a.status = ST_NOSLOT;
                        return a;
                    end
                    // Top slot taken: search again below the home slot.
                    if (idx >= SLOTS - 1)
                    begin
                        idx    = home;
                        upward = 1'b0;
                    end
                    idx = upward ? idx + 1 : idx - 1;
                end
                slot_taken[idx]  = 1'b1;
                slot_owner[idx]  = entries_used[FIELD_W-1:0];
                a.entry_number   = entries_used[FIELD_W-1:0];
                a.slot           = idx[FIELD_W-1:0];
                entries_used++;
            end
            MODE_FETCH:
            begin
                idx = fetch_pos;
                while (idx < SLOTS && !slot_taken[idx])
                    idx++;
                if (idx >= SLOTS)
                begin
                    fetch_pos = SLOTS;
                    a.status  = ST_END;
                end
                else
                begin
                    fetch_pos      = idx + 1;
                    a.entry_number = slot_owner[idx];
                    a.slot         = idx[FIELD_W-1:0];
                end
            end
            default:
                a.status = ST_END;
        endcase
        return a;
    endfunction

    task automatic check_field(string what, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
        if (got !== want)
        begin
            if (mismatch_count < PRINT_LIMIT)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dot_out_t want;
        if (!rst_n)
        begin
            rows_cfg = ROWS_W'(ROWS_AT_RESET);
            foreach (slot_taken[i])
                slot_taken[i] = 1'b0;
            entries_used = 0;
            fetch_pos    = 0;
            awaited_answers.delete();
            foreach (hits[i])
                hits[i] = 0;
        end
        else
        begin
            if (start && !busy)
                awaited_answers.push_back(answer_for(cmd));
            if (cfg_wr_en)
                rows_cfg = cfg_wr_data;
            if (done)
            begin
                if (awaited_answers.size() == 0)
                begin
                    if (mismatch_count < PRINT_LIMIT)
                        $display("%0t ns: expected no result beat, got status %0d entry %0d slot %0d",
                                 $time, result.status, result.entry_number, result.slot);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    hits[want.status]++;
                    check_field("status", FIELD_W'(want.status), FIELD_W'(result.status));
                    check_field("entry_number", want.entry_number, result.entry_number);
                    check_field("slot", want.slot, result.slot);
                end
            end
        end
        errors      <= mismatch_count;
        outstanding <= awaited_answers.size();
        ok_hits     <= hits[ST_OK];
        full_hits   <= hits[ST_FULL];
        noslot_hits <= hits[ST_NOSLOT];
        end_hits    <= hits[ST_END];
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the depth ordering table: stimulus, pacing and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dot_pkg::*;

    localparam int ROWS_AT_RESET = 240;
    // Longest single command: a fetch or a probe over every slot.
    localparam int LONGEST_BEAT  = 2 * SLOTS + 64;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    dot_in_t           cmd = '0;
    logic              cfg_wr_en = 1'b0;
    logic [ROWS_W-1:0] cfg_wr_data = '0;
    logic              done;
    dot_out_t          result;

    int errors;
    int outstanding;
    int ok_hits;
    int full_hits;
    int noslot_hits;
    int end_hits;

    // Bookkeeping for pacing and the closing summary.
    logic [ROWS_W-1:0] height_now = ROWS_W'(ROWS_AT_RESET);
    int                burst_left = 0;
    int                sent_by_mode [4] = '{0, 0, 0, 0};
    int                heights_tried = 1;

    always #5 clk = ~clk;

    depth_ordering_table_insert DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    // The checker sees exactly what the block sees and keeps its own copy of the table.
    dot_answer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding),
        .ok_hits     (ok_hits),
        .full_hits   (full_hits),
        .noslot_hits (noslot_hits),
        .end_hits    (end_hits)
    );

    // The sender works in bursts. When a burst runs out, start drops for a random gap
    // and the command bus carries junk; a new burst length is drawn as well. Short gaps
    // are the rule; long ones land in the middle of the divider or a probe, and the
    // occasional very long burst gives stretches with no idling at all.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
        start    <= 1'b0;
        cmd.mode <= dot_mode_t'($urandom_range(0, 3));
        cmd.row  <= ROW_W'($urandom);
        repeat (gap) @(posedge clk);
    endtask

    // Offers one command beat and holds it until the block takes it, that is until a
    // rising edge sees start high with busy low. Start is left high on return so that
    // back-to-back beats never drop it.
    task automatic issue(dot_mode_t mode, logic signed [ROW_W-1:0] row);
        pace();
        start    <= 1'b1;
        cmd.mode <= mode;
        cmd.row  <= row;
        do @(posedge clk); while (busy);
        sent_by_mode[mode]++;
    endtask

    // Waits until every awaited answer has come back and the block is idle again.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // Screen height is only changed while the block is idle.
    task automatic set_height(logic [ROWS_W-1:0] rows);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rows;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        height_now   = rows;
        heights_tried++;
    endtask

    // Rows for inserts. Many fall on the visible screen so homes spread over the table;
    // the rest are zero, negative, right at the bottom edge, or any 16-bit value.
    function automatic logic signed [ROW_W-1:0] pick_row();
        int h;
        h = (height_now == 0) ? 1 : int'(height_now);
        case ($urandom_range(0, 7))
            0:       return ROW_W'($urandom);
            1:       return ROW_W'(0 - int'($urandom_range(1, 32768)));
            2:       return '0;
            3:       return ROW_W'(h);
            4:       return ROW_W'(h - 1);
            default: return ROW_W'($urandom_range(1, h));
        endcase
    endfunction

    // Random traffic. Most of it is shaped like a real frame: usually a clear, a run
    // of inserts, then fetches to read the table back (up to two past the end), with
    // an insert slipped in now and then among the reads. The rest is single
    // beats of any mode, the unused one included.
    task automatic random_frames(int budget);
        int n;
        int sent;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    issue(MODE_CLEAR, ROW_W'($urandom));
                    sent++;
                end
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                repeat (n)
                begin
                    issue(MODE_INSERT, pick_row());
                    sent++;
                end
                repeat (n + $urandom_range(0, 2))
                begin
                    if ($urandom_range(0, 5) == 0)
                        issue(MODE_INSERT, pick_row());
                    else
                        issue(MODE_FETCH, ROW_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                issue(dot_mode_t'($urandom_range(0, 3)), pick_row());
                sent++;
            end
        end
    endtask

    // With a height of SLOTS-1 a row maps straight onto its slot, so the top rows fill
    // the upper end of the table, the last one probing into the top slot. The largest
    // row then finds its home and the top slot taken and walks down past the whole
    // crowded run, a longer way each time. A row at zero takes slot 0 and the next one
    // is turned away. Reading everything back checks every stored entry number and
    // runs into the end of the table.
    task automatic crowd_top_of_table();
        set_height(ROWS_W'(SLOTS - 1));
        issue(MODE_CLEAR, '0);
        for (int r = SLOTS - 24; r < SLOTS; r++)
            issue(MODE_INSERT, ROW_W'(r));
        repeat (4) issue(MODE_INSERT, 16'sh7FFF);
        issue(MODE_INSERT, '0);
        issue(MODE_INSERT, -16'sd3);
        repeat (31) issue(MODE_FETCH, '0);
        issue(MODE_CLEAR, '0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Right after reset the block sweeps its memory with busy high; issue() simply
        // waits that out. The reset screen height of 240 rows is used first.

        // Reading an empty table runs to its end, and the cursor stays there.
        issue(MODE_FETCH, '0);
        issue(MODE_FETCH, 16'sh7FFF);
        issue(MODE_NONE, 16'sh1234);
        // Rows at or below zero all go home to slot 0; once it is taken they are
        // rejected without probing.
        issue(MODE_INSERT, '0);
        issue(MODE_INSERT, -16'sd32768);
        issue(MODE_INSERT, -16'sd1);
        // The largest row clamps to the slot below the top. Row 239 lands four slots
        // under it, row 240 probes up into the top slot, and row 241 finds both taken
        // and turns downward from its home.
        issue(MODE_INSERT, 16'sh7FFF);
        issue(MODE_INSERT, 16'sd239);
        issue(MODE_INSERT, 16'sd240);
        issue(MODE_INSERT, 16'sd241);
        issue(MODE_INSERT, 16'sd1);
        // The cursor is still parked past the end, so nothing new is returned.
        issue(MODE_FETCH, '0);
        issue(MODE_CLEAR, 16'sh7FFF);
        // After a clear: read one entry, then insert below the cursor. That late
        // entry must stay hidden until the next clear.
        issue(MODE_INSERT, 16'sd120);
        issue(MODE_FETCH, '0);
        issue(MODE_INSERT, 16'sd1);
        issue(MODE_FETCH, '0);
        issue(MODE_INSERT, 16'sh5555);
        issue(MODE_INSERT, 16'shAAAA);
        issue(MODE_NONE, 16'shAAAA);
        issue(MODE_CLEAR, '0);

        crowd_top_of_table();

        // Random phases, each under its own screen height. Zero must act as one row,
        // one row and the full 12-bit height are the extremes, and the reset value
        // comes back before a last, small random height.
        set_height('0);
        random_frames(40);
        set_height(ROWS_W'(1));
        random_frames(40);
        set_height('1);
        random_frames(40);
        set_height(ROWS_W'(SLOTS - 1));
        random_frames(40);
        set_height(ROWS_W'($urandom_range(2, 4094)));
        random_frames(40);
        set_height(ROWS_W'(ROWS_AT_RESET));
        random_frames(40);
        set_height(ROWS_W'($urandom_range(2, 64)));
        random_frames(40);

        // Drain, then leave room for any stray result beat to show up.
        settle();
        repeat (LONGEST_BEAT) @(posedge clk);

        $display("Sent %0d clear, %0d insert, %0d fetch and %0d unused-mode beats under %0d screen heights.",
                 sent_by_mode[MODE_CLEAR], sent_by_mode[MODE_INSERT],
                 sent_by_mode[MODE_FETCH], sent_by_mode[MODE_NONE], heights_tried);
        $display("Answers: %0d ok, %0d store full, %0d no free slot, %0d end of table; %0d mismatches.",
                 ok_hits, full_hits, noslot_hits, end_hits, errors);
        if (errors == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #60ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
